### hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler angle to quaternion package
// Shared widths, fixed-point constants, the CORDIC arctangent table and the
// sine and cosine bundle passed from each CORDIC lane to the product stages.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);

   localparam int XY_W       = 34;
   localparam int Z_W        = 33;
   localparam int Z_SHIFT    = 32 - ANGLE_BITS;
   localparam int CORDIC_GAIN = 652032874;

   localparam int TRIG_W     = 22;
   localparam int TRIG_SHIFT = 10;
   localparam int TRIG_ONE   = 1 << 20;

   localparam int PAIR_W      = 2 * TRIG_W;
   localparam int SPLIT       = 21;
   localparam int HI_W        = PAIR_W - SPLIT;
   localparam int HI_PROD_W   = HI_W + TRIG_W;
   localparam int LO_PROD_W   = SPLIT + 1 + TRIG_W;
   localparam int SUM_W       = 64;
   localparam int QUAT_SHIFT  = 46;
   localparam int QUAT_W      = 16;
   localparam int QUAT_ONE    = 16384;

   localparam int PIPE_DEPTH  = CORDIC_STEPS + 6;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

   function automatic logic signed [Z_W-1:0] atan_turns(input logic [STEP_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:  val = Z_W'(536870912);
         5'd1:  val = Z_W'(316933406);
         5'd2:  val = Z_W'(167458907);
         5'd3:  val = Z_W'(85004756);
         5'd4:  val = Z_W'(42667331);
         5'd5:  val = Z_W'(21354465);
         5'd6:  val = Z_W'(10679838);
         5'd7:  val = Z_W'(5340245);
         5'd8:  val = Z_W'(2670163);
         5'd9:  val = Z_W'(1335087);
         5'd10: val = Z_W'(667544);
         5'd11: val = Z_W'(333772);
         5'd12: val = Z_W'(166886);
         5'd13: val = Z_W'(83443);
         5'd14: val = Z_W'(41722);
         5'd15: val = Z_W'(20861);
         5'd16: val = Z_W'(10430);
         5'd17: val = Z_W'(5215);
         5'd18: val = Z_W'(2608);
         5'd19: val = Z_W'(1304);
         5'd20: val = Z_W'(652);
         5'd21: val = Z_W'(326);
         5'd22: val = Z_W'(163);
         5'd23: val = Z_W'(81);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### hw/rtl/euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// Euler angle to quaternion core
// Converts yaw, pitch and roll binary angles into the Z-Y-X unit quaternion
// in signed Q1.14, rounded to nearest and clamped to plus or minus one.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is always low.
// The rate is set by the 24-stage CORDIC lanes and the product pipeline,
// each stage holding one CORDIC iteration or one step of the products and sums.
// Reset clears the valid bits only; no result appears until a request has
// passed through, and the receiver cannot stall.
module euler_to_quaternion_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    req_yaw_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    req_pitch_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    req_roll_angle,
   output logic                                     rsp_strobe,
   output logic signed [e2q_pkg::QUAT_W-1:0]        rsp_quat_x,
   output logic signed [e2q_pkg::QUAT_W-1:0]        rsp_quat_y,
   output logic signed [e2q_pkg::QUAT_W-1:0]        rsp_quat_z,
   output logic signed [e2q_pkg::QUAT_W-1:0]        rsp_quat_w
);
   import e2q_pkg::*;

   localparam int QS_W = SUM_W - QUAT_SHIFT;
   localparam logic signed [SUM_W-1:0] QUAT_HALF = SUM_W'(64'h0000_2000_0000_0000);
   localparam logic signed [QS_W-1:0]  QUAT_POS  = QS_W'(QUAT_ONE);
   localparam logic signed [QS_W-1:0]  QUAT_NEG  = -QS_W'(QUAT_ONE);

   logic                  accept;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] valid_ff;

   trig_type yaw_trig;
   trig_type pitch_trig;
   trig_type roll_trig;
   trig_type roll_ff;

   logic signed [PAIR_W-1:0]    pair_in [4];
   logic signed [PAIR_W-1:0]    pair_ff [4];
   logic signed [HI_PROD_W-1:0] srp_hi_ff [4];
   logic signed [LO_PROD_W-1:0] srp_lo_ff [4];
   logic signed [HI_PROD_W-1:0] crp_hi_ff [4];
   logic signed [LO_PROD_W-1:0] crp_lo_ff [4];
   logic signed [SUM_W-1:0]     srp_ff [4];
   logic signed [SUM_W-1:0]     crp_ff [4];
   logic signed [SUM_W-1:0]     sum_in [4];
   logic signed [SUM_W-1:0]     sum_ff [4];
   logic signed [QS_W-1:0]      quat_scaled [4];
   logic signed [QUAT_W-1:0]    quat_in [4];
   logic signed [QUAT_W-1:0]    quat_ff [4];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   e2q_cordic u_yaw_cordic (
      .clock (clock),
      .angle (req_yaw_angle),
      .trig  (yaw_trig)
   );

   e2q_cordic u_pitch_cordic (
      .clock (clock),
      .angle (req_pitch_angle),
      .trig  (pitch_trig)
   );

   e2q_cordic u_roll_cordic (
      .clock (clock),
      .angle (req_roll_angle),
      .trig  (roll_trig)
   );

   // Pair products: cp*cy, sp*sy, cp*sy, sp*cy.
   assign pair_in[0] = pitch_trig.cos_val * yaw_trig.cos_val;
   assign pair_in[1] = pitch_trig.sin_val * yaw_trig.sin_val;
   assign pair_in[2] = pitch_trig.cos_val * yaw_trig.sin_val;
   assign pair_in[3] = pitch_trig.sin_val * yaw_trig.cos_val;

   always_ff @(posedge clock) begin
      roll_ff <= roll_trig;
      for (int k = 0; k < 4; k++) begin
         pair_ff[k] <= pair_in[k];
      end
   end

   // Each pair product is split so that the roll multiply stays narrow.
   for (genvar j = 0; j < 4; j++) begin : g_triple
      logic signed [HI_W-1:0]   pair_hi;
      logic signed [SPLIT:0]    pair_lo;
      logic signed [HI_PROD_W-1:0] srp_hi_in;
      logic signed [LO_PROD_W-1:0] srp_lo_in;
      logic signed [HI_PROD_W-1:0] crp_hi_in;
      logic signed [LO_PROD_W-1:0] crp_lo_in;

      assign pair_hi   = pair_ff[j][PAIR_W-1:SPLIT];
      assign pair_lo   = {1'b0, pair_ff[j][SPLIT-1:0]};
      assign srp_hi_in = roll_ff.sin_val * pair_hi;
      assign srp_lo_in = roll_ff.sin_val * pair_lo;
      assign crp_hi_in = roll_ff.cos_val * pair_hi;
      assign crp_lo_in = roll_ff.cos_val * pair_lo;

      always_ff @(posedge clock) begin
         srp_hi_ff[j] <= srp_hi_in;
         srp_lo_ff[j] <= srp_lo_in;
         crp_hi_ff[j] <= crp_hi_in;
         crp_lo_ff[j] <= crp_lo_in;
         srp_ff[j]    <= (SUM_W'(srp_hi_ff[j]) <<< SPLIT) + SUM_W'(srp_lo_ff[j]);
         crp_ff[j]    <= (SUM_W'(crp_hi_ff[j]) <<< SPLIT) + SUM_W'(crp_lo_ff[j]);
      end
   end

   assign sum_in[0] = srp_ff[0] - crp_ff[1] + QUAT_HALF;
   assign sum_in[1] = crp_ff[3] + srp_ff[2] + QUAT_HALF;
   assign sum_in[2] = crp_ff[2] - srp_ff[3] + QUAT_HALF;
   assign sum_in[3] = crp_ff[0] + srp_ff[1] + QUAT_HALF;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         quat_scaled[k] = sum_ff[k][SUM_W-1:QUAT_SHIFT];
         if (quat_scaled[k] > QUAT_POS) begin
            quat_scaled[k] = QUAT_POS;
         end else if (quat_scaled[k] < QUAT_NEG) begin
            quat_scaled[k] = QUAT_NEG;
         end
         quat_in[k] = quat_scaled[k][QUAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         sum_ff[k]  <= sum_in[k];
         quat_ff[k] <= quat_in[k];
      end
   end

   assign rsp_strobe = valid_ff[PIPE_DEPTH-1];
   assign rsp_quat_x = quat_ff[0];
   assign rsp_quat_y = quat_ff[1];
   assign rsp_quat_z = quat_ff[2];
   assign rsp_quat_w = quat_ff[3];

endmodule

### hw/rtl/e2q_cordic.sv
// ----------------------------------------------------------------------------
// Half-angle sine and cosine lane
// Halves a binary angle and runs a fully pipelined rotation-mode CORDIC,
// one iteration per register stage, then rounds and clamps to Q1.20.
// ----------------------------------------------------------------------------
module e2q_cordic (
   input  logic                                     clock,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    angle,
   output e2q_pkg::trig_type                        trig
);
   import e2q_pkg::*;

   localparam logic signed [XY_W-1:0] X_INIT     = XY_W'(CORDIC_GAIN);
   localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(1 << (TRIG_SHIFT - 1));
   localparam logic signed [XY_W-1:0] TRIG_POS   = XY_W'(TRIG_ONE);
   localparam logic signed [XY_W-1:0] TRIG_NEG   = -XY_W'(TRIG_ONE);

   logic signed [ANGLE_BITS-1:0] half_angle;
   logic signed [Z_W-1:0]        z_init;

   logic signed [XY_W-1:0] x_src [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_src [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_src [CORDIC_STEPS];
   logic signed [XY_W-1:0] x_in  [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_in  [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_in  [CORDIC_STEPS];
   logic signed [XY_W-1:0] x_ff  [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff  [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff  [CORDIC_STEPS];

   logic signed [XY_W-1:0] cos_round;
   logic signed [XY_W-1:0] sin_round;
   trig_type               trig_in;
   trig_type               trig_ff;

   assign half_angle = angle >>> 1;
   assign z_init     = $signed(Z_W'(half_angle)) <<< Z_SHIFT;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      if (i == 0) begin : g_first
         assign x_src[i] = X_INIT;
         assign y_src[i] = '0;
         assign z_src[i] = z_init;
      end else begin : g_next
         assign x_src[i] = x_ff[i-1];
         assign y_src[i] = y_ff[i-1];
         assign z_src[i] = z_ff[i-1];
      end

      assign x_in[i] = z_src[i][Z_W-1] ? x_src[i] + (y_src[i] >>> i)
                                       : x_src[i] - (y_src[i] >>> i);
      assign y_in[i] = z_src[i][Z_W-1] ? y_src[i] - (x_src[i] >>> i)
                                       : y_src[i] + (x_src[i] >>> i);
      assign z_in[i] = z_src[i][Z_W-1] ? z_src[i] + atan_turns(STEP_IDX_W'(i))
                                       : z_src[i] - atan_turns(STEP_IDX_W'(i));

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
         z_ff[i] <= z_in[i];
      end
   end

   always_comb begin
      cos_round = (x_ff[CORDIC_STEPS-1] + ROUND_HALF) >>> TRIG_SHIFT;
      sin_round = (y_ff[CORDIC_STEPS-1] + ROUND_HALF) >>> TRIG_SHIFT;
      if (cos_round > TRIG_POS) begin
         cos_round = TRIG_POS;
      end else if (cos_round < TRIG_NEG) begin
         cos_round = TRIG_NEG;
      end
      if (sin_round > TRIG_POS) begin
         sin_round = TRIG_POS;
      end else if (sin_round < TRIG_NEG) begin
         sin_round = TRIG_NEG;
      end
      trig_in.cos_val = cos_round[TRIG_W-1:0];
      trig_in.sin_val = sin_round[TRIG_W-1:0];
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
   end

   assign trig = trig_ff;

endmodule
